// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// Holds the parse phase encoding, header code values and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // Parse phases of one frame.
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } wsd_phase_e;

  localparam logic [3:0] OPC_CLOSE      = 4'h8;
  localparam logic [6:0] LEN7_EXT16     = 7'd126;
  localparam logic [6:0] LEN7_EXT64     = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [1:0] KEY_LAST_INDEX = 2'd3;

  // One result of the parser, valid only together with a step.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    logic       close;
  } wsd_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wsd_parser.sv -----
// Frame header parser and payload unmasking for the WebSocket deframer.
// Holds all parse state; depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  wire [7:0]            byte_i,
  output wsd_pkg::wsd_result_t result_o
);
  import wsd_pkg::*;

  wsd_phase_e  phase_q, phase_d;
  logic [3:0]  ext_count_q, ext_count_d;
  logic [63:0] remaining_len_q, remaining_len_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [1:0]  key_index_q, key_index_d;
  logic [3:0]  hdr_opcode_q, hdr_opcode_d;
  logic        hdr_fin_q, hdr_fin_d;
  logic        hdr_masked_q, hdr_masked_d;
  logic        halted_q, halted_d;

  // Derived values for the two decoders; key_byte and key_shift serve only the result decoder.
  logic [6:0]  len7;
  logic [3:0]  ext_cnt_dec;
  logic [63:0] rem_shift;
  logic        data_last;
  logic [7:0]  key_byte;
  logic [4:0]  key_shift;

  assign len7        = byte_i[6:0];
  assign ext_cnt_dec = (ext_count_q == 4'd0) ? 4'd0 : ext_count_q - 4'd1;
  assign rem_shift   = {remaining_len_q[55:0], byte_i};
  assign data_last   = (remaining_len_q[63:1] == 63'd0);
  // Key byte 0 sits in the top byte of the key register.
  assign key_shift   = {~key_index_q, 3'b000};
  assign key_byte    = mask_key_q[key_shift +: 8];

  // Result decoder.
  always_comb begin
    result_o        = '0;
    result_o.opcode = hdr_opcode_q;
    result_o.fin    = hdr_fin_q;
    if (!halted_q) begin
      unique case (phase_q)
        PH_HDR1: begin
          if (len7 != LEN7_EXT16 && len7 != LEN7_EXT64 && !byte_i[7] && len7 == 7'd0) begin
            result_o.valid = 1'b1;
            result_o.last  = 1'b1;
          end
        end
        PH_EXT: begin
          if (ext_cnt_dec == 4'd0 && !hdr_masked_q && rem_shift == 64'd0) begin
            result_o.valid = 1'b1;
            result_o.last  = 1'b1;
          end
        end
        PH_KEY: begin
          if (key_index_q == KEY_LAST_INDEX && remaining_len_q == 64'd0) begin
            result_o.valid = 1'b1;
            result_o.last  = 1'b1;
          end
        end
        PH_DATA: begin
          result_o.valid     = 1'b1;
          result_o.has_data  = 1'b1;
          result_o.data_byte = hdr_masked_q ? (byte_i ^ key_byte) : byte_i;
          result_o.last      = data_last;
        end
        default: begin
          result_o.valid = 1'b0;
        end
      endcase
    end
    result_o.close = result_o.last && (hdr_opcode_q == OPC_CLOSE);
  end

  // Next-state decoder.
  always_comb begin
    phase_d         = phase_q;
    ext_count_d     = ext_count_q;
    remaining_len_d = remaining_len_q;
    mask_key_d      = mask_key_q;
    key_index_d     = key_index_q;
    hdr_opcode_d    = hdr_opcode_q;
    hdr_fin_d       = hdr_fin_q;
    hdr_masked_d    = hdr_masked_q;
    halted_d        = halted_q;
    if (step_i && !halted_q) begin
      unique case (phase_q)
        PH_HDR1: begin
          hdr_masked_d    = byte_i[7];
          remaining_len_d = 64'd0;
          if (len7 == LEN7_EXT16) begin
            ext_count_d = EXT16_BYTES;
            phase_d     = PH_EXT;
          end else if (len7 == LEN7_EXT64) begin
            ext_count_d = EXT64_BYTES;
            phase_d     = PH_EXT;
          end else begin
            remaining_len_d = {57'd0, len7};
            key_index_d     = 2'd0;
            if (byte_i[7]) begin
              phase_d    = PH_KEY;
              mask_key_d = 32'd0;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_EXT: begin
          remaining_len_d = rem_shift;
          ext_count_d     = ext_cnt_dec;
          if (ext_cnt_dec == 4'd0) begin
            key_index_d = 2'd0;
            if (hdr_masked_q) begin
              phase_d    = PH_KEY;
              mask_key_d = 32'd0;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_KEY: begin
          mask_key_d = {mask_key_q[23:0], byte_i};
          if (key_index_q == KEY_LAST_INDEX) begin
            key_index_d = 2'd0;
            phase_d     = PH_DATA;
          end else begin
            key_index_d = key_index_q + 2'd1;
          end
        end
        PH_DATA: begin
          key_index_d     = key_index_q + 2'd1;
          remaining_len_d = data_last ? 64'd0 : remaining_len_q - 64'd1;
        end
        default: begin
          hdr_fin_d       = byte_i[7];
          hdr_opcode_d    = byte_i[3:0];
          hdr_masked_d    = 1'b0;
          ext_count_d     = 4'd0;
          remaining_len_d = 64'd0;
          key_index_d     = 2'd0;
          phase_d         = PH_HDR1;
        end
      endcase
      // The end of a frame returns to the first header byte.
      if (result_o.valid && result_o.last) begin
        phase_d     = PH_HDR0;
        key_index_d = 2'd0;
        if (result_o.close) begin
          halted_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HDR0;
      ext_count_q     <= 4'd0;
      remaining_len_q <= 64'd0;
      mask_key_q      <= 32'd0;
      key_index_q     <= 2'd0;
      hdr_opcode_q    <= 4'd0;
      hdr_fin_q       <= 1'b0;
      hdr_masked_q    <= 1'b0;
      halted_q        <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      ext_count_q     <= ext_count_d;
      remaining_len_q <= remaining_len_d;
      mask_key_q      <= mask_key_d;
      key_index_q     <= key_index_d;
      hdr_opcode_q    <= hdr_opcode_d;
      hdr_fin_q       <= hdr_fin_d;
      hdr_masked_q    <= hdr_masked_d;
      halted_q        <= halted_d;
    end
  end

  // A payload phase always has at least one byte left to deliver.
  a_data_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (remaining_len_q != 64'd0))
    else $error("payload phase with zero remaining length");

  // Completing a close frame halts the parser on the next cycle.
  a_close_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.valid && result_o.close) |=> halted_q)
    else $error("close frame completed without halting");

  // Once halted, the parser stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  // A halted parser produces no results.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !result_o.valid)
    else $error("result produced while halted");

endmodule

`default_nettype wire

// ----- hw/rtl/websocket_frame_deframer_top.sv -----
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg and wsd_parser.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o | rx_byte_i
//   out     | output    | out_valid_o/ out_stall_i| data_byte_o, has_data_o, frame_opcode_o,
//           |           |                         | frame_final_o, frame_last_o, close_seen_o
//
// One byte transaction is accepted per cycle while the output does not stall. A byte waits in
// the input register while the parser works on it, and the result register takes the outcome
// when it has room. Header, extended length and key bytes give no result, except the byte that
// completes the header of a frame with an empty payload.
// Reset is asynchronous and active low; it returns the parser to the first header byte and
// empties both registers. A stall on the output holds the result register and backs up into
// the input register, which then raises in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  // Received byte stream.
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [7:0]  rx_byte_i,
  // Deframed payload bytes.
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       has_data_o,
  output logic [3:0] frame_opcode_o,
  output logic       frame_final_o,
  output logic       frame_last_o,
  output logic       close_seen_o
);
  import wsd_pkg::*;

  // Input register: one byte waiting for the parser.
  logic        in_valid_q;
  logic [7:0]  in_byte_q;

  // Result register.
  logic        out_valid_q;
  wsd_result_t out_res_q;

  logic        out_ready;
  logic        step;
  wsd_result_t result;

  // The result register can take a new result when it is empty or being drained this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  // The parser advances by one byte whenever a byte is held and its result has a place to go.
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  wsd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= step && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && step && result.valid) begin
      out_res_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_res_q.data_byte;
  assign has_data_o     = out_res_q.has_data;
  assign frame_opcode_o = out_res_q.opcode;
  assign frame_final_o  = out_res_q.fin;
  assign frame_last_o   = out_res_q.last;
  assign close_seen_o   = out_res_q.close;

endmodule

`default_nettype wire

// ----- tb/websocket_frame_deframer_top_tb.sv -----
// Self-checking testbench for websocket_frame_deframer_top.
// Drives a byte stream of WebSocket frames and checks every deframed result against a
// behavioral predictor of the parser. Depends on wsd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
  import wsd_pkg::*;

  // The drain wait leaves a wide margin over the path through the input and result registers.
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned RANDOM_TARGET = 850;

  // Ways to encode the payload length in the second header byte.
  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  // One deframed result as the block should present it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    logic       close;
  } deframed_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic       has_data_o;
  logic [3:0] frame_opcode_o;
  logic       frame_final_o;
  logic       frame_last_o;
  logic       close_seen_o;

  websocket_frame_deframer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .has_data_o    (has_data_o),
    .frame_opcode_o(frame_opcode_o),
    .frame_final_o (frame_final_o),
    .frame_last_o  (frame_last_o),
    .close_seen_o  (close_seen_o)
  );

  // Predicted results still waiting for the block, oldest first.
  deframed_t deframed_q[$];

  // Parser state kept by the predictor. It mirrors what a correct deframer must hold:
  // the phase, the bytes of extended length still due, the payload bytes still due,
  // the masking key and its byte index, the header fields and the halt flag.
  wsd_phase_e  parse_phase;
  logic [3:0]  ext_left;
  logic [63:0] payload_left;
  logic [31:0] mask_key;
  logic [1:0]  key_idx;
  logic [3:0]  cur_opcode;
  logic        cur_fin;
  logic        cur_masked;
  logic        stream_halted;

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned frames_sent;
  int unsigned cycle_count;
  int unsigned burst_left;
  deframed_t   want;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Queues one expected result. The last result of a frame returns the parser to the first
  // header byte, and when that frame is a close frame the stream halts for good.
  function automatic void push_deframed(input logic [7:0] d, input logic has, input logic last);
    deframed_t r;
    r.data_byte = d;
    r.has_data  = has;
    r.opcode    = cur_opcode;
    r.fin       = cur_fin;
    r.last      = last;
    r.close     = last && (cur_opcode == OPC_CLOSE);
    if (last) begin
      parse_phase = PH_HDR0;
      key_idx     = '0;
      if (r.close) begin
        stream_halted = 1'b1;
      end
    end
    deframed_q.push_back(r);
  endfunction

  // The header is complete: a frame with no payload ends right here with a marker result.
  function automatic void finish_header();
    key_idx = '0;
    if (payload_left == '0) begin
      push_deframed(8'h00, 1'b0, 1'b1);
    end else begin
      parse_phase = PH_DATA;
    end
  endfunction

  // The length is known: a masked frame goes on to collect its key.
  function automatic void finish_length();
    if (cur_masked) begin
      parse_phase = PH_KEY;
      key_idx     = '0;
      mask_key    = '0;
    end else begin
      finish_header();
    end
  endfunction

  // Advances the predicted parser by one accepted byte.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] key_byte;
    if (stream_halted) begin
      return;
    end
    case (parse_phase)
      PH_HDR1: begin
        len7         = b[6:0];
        cur_masked   = b[7];
        payload_left = '0;
        if (len7 == LEN7_EXT16) begin
          ext_left    = EXT16_BYTES;
          parse_phase = PH_EXT;
        end else if (len7 == LEN7_EXT64) begin
          ext_left    = EXT64_BYTES;
          parse_phase = PH_EXT;
        end else begin
          payload_left = {57'd0, len7};
          finish_length();
        end
      end
      PH_EXT: begin
        // Extended length arrives big-endian.
        payload_left = {payload_left[55:0], b};
        if (ext_left != '0) begin
          ext_left = ext_left - 4'd1;
        end
        if (ext_left == '0) begin
          finish_length();
        end
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (key_idx == KEY_LAST_INDEX) begin
          finish_header();
        end else begin
          key_idx = key_idx + 2'd1;
        end
      end
      PH_DATA: begin
        // The first key byte sits in the top bits and unmasks payload offset zero.
        key_byte = mask_key[31 - 8 * key_idx -: 8];
        key_idx  = key_idx + 2'd1;
        if (payload_left != '0) begin
          payload_left = payload_left - 64'd1;
        end
        push_deframed(cur_masked ? (b ^ key_byte) : b, 1'b1, payload_left == '0);
      end
      default: begin
        // First header byte; any unused phase code lands here too. Bits 6..4 are ignored.
        cur_fin      = b[7];
        cur_opcode   = b[3:0];
        cur_masked   = 1'b0;
        ext_left     = '0;
        payload_left = '0;
        key_idx      = '0;
        parse_phase  = PH_HDR1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Clock, cycle limit and receiver stalls
  // ---------------------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, deframed_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own: it switches between spans with no stall,
  // light random stalls, heavy random stalls and long stall runs, so that back pressure
  // reaches the input register at every phase of a frame.
  initial begin : stall_pattern
    int unsigned stall_mode;
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      span       = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              out_stall_i <= ~out_stall_i;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned expected);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, expected);
    error_count++;
  endtask

  // Every result transaction is matched against the oldest prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deframed_q.size() == 0) begin
        report_mismatch("unexpected result, data_byte", data_byte_o, 0);
      end else begin
        want = deframed_q.pop_front();
        results_checked++;
        if (data_byte_o !== want.data_byte) begin
          report_mismatch("data_byte", data_byte_o, want.data_byte);
        end
        if (has_data_o !== want.has_data) begin
          report_mismatch("has_data", has_data_o, want.has_data);
        end
        if (frame_opcode_o !== want.opcode) begin
          report_mismatch("frame_opcode", frame_opcode_o, want.opcode);
        end
        if (frame_final_o !== want.fin) begin
          report_mismatch("frame_final", frame_final_o, want.fin);
        end
        if (frame_last_o !== want.last) begin
          report_mismatch("frame_last", frame_last_o, want.last);
        end
        if (close_seen_o !== want.close) begin
          report_mismatch("close_seen", close_seen_o, want.close);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  // Sends one byte transaction. Called at a falling edge and returns at a falling edge.
  // The sender works in bursts: when a burst runs out it drops valid for a random gap,
  // which may be empty so that long runs of back-to-back bytes occur as well.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    // The byte is taken at the first rising edge without stall; the payload holds till then.
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    deframe_byte(b);
    bytes_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Sends a whole frame: header, extended length, key when masked, then random payload.
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                            input logic masked, input len_form_e form, input logic [63:0] len);
    logic [31:0] key;
    key = $urandom();
    send_byte({fin, rsv, opcode});
    case (form)
      LEN_EXT16: begin
        send_byte({masked, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      LEN_EXT64: begin
        send_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) begin
          send_byte(len[8 * i +: 8]);
        end
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) begin
        send_byte(key[8 * i +: 8]);
      end
    end
    for (longint unsigned n = 0; n < len; n++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
    frames_sent++;
  endtask

  // Frames with an empty payload: unmasked (marker on the second header byte) and masked
  // (marker on the last key byte). The masked one is a continuation frame with an all-zero first header byte.
  task automatic test_empty_frames();
    send_frame(1'b1, 3'b000, 4'h9, 1'b0, LEN_SHORT, 64'd0);
    send_frame(1'b0, 3'b000, 4'h0, 1'b1, LEN_SHORT, 64'd0);
  endtask

  // An all-ones first header byte: fin set, every reserved bit set, opcode 15. The payload is
  // masked, so the reserved bits must not leak into the opcode and the key must apply.
  task automatic test_reserved_bits_and_masking();
    send_frame(1'b1, 3'b111, 4'hf, 1'b1, LEN_SHORT, 64'd2);
  endtask

  // Both extended length forms: a 16-bit length of one and a 64-bit length of zero.
  task automatic test_extended_lengths();
    send_frame(1'b1, 3'b000, 4'h2, 1'b0, LEN_EXT16, 64'd1);
    send_frame(1'b0, 3'b010, 4'h1, 1'b0, LEN_EXT64, 64'd0);
  endtask

  // Well-formed frames with random header fields and payloads. Most frames are short, with
  // a few longer ones in each length form. Close frames are held back for the final test,
  // since one of them halts the stream for the rest of the run.
  task automatic test_random_frames();
    logic [3:0]  opcode;
    logic [63:0] len;
    len_form_e   form;
    int unsigned pick;
    while (bytes_sent < RANDOM_TARGET) begin
      do begin
        opcode = 4'($urandom_range(0, 15));
      end while (opcode == OPC_CLOSE);
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        form = LEN_SHORT;
        len  = 64'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 9));
      end else if (pick < 17) begin
        form = LEN_EXT16;
        len  = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(126, 300)
                                                : $urandom_range(0, 12));
      end else begin
        form = LEN_EXT64;
        len  = 64'($urandom_range(0, 24));
      end
      send_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), opcode,
                 1'($urandom_range(0, 1)), form, len);
    end
  endtask

  // A masked, non-final close frame ends the run. Once it completes, every following byte
  // must be dropped, including a full empty ping frame that would otherwise give a result.
  task automatic test_close_then_halt();
    send_frame(1'b0, 3'b000, OPC_CLOSE, 1'b1, LEN_SHORT, 64'd3);
    send_byte(8'h89);
    send_byte(8'h00);
    repeat (12) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    in_valid_i    = 1'b0;
    rx_byte_i     = 8'h00;
    rst_ni        = 1'b0;
    parse_phase   = PH_HDR0;
    ext_left      = '0;
    payload_left  = '0;
    mask_key      = '0;
    key_idx       = '0;
    cur_opcode    = '0;
    cur_fin       = 1'b0;
    cur_masked    = 1'b0;
    stream_halted = 1'b0;
    error_count     = 0;
    bytes_sent      = 0;
    results_checked = 0;
    frames_sent     = 0;
    cycle_count     = 0;
    burst_left      = 0;

    // Reset is released on a falling edge.
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_frames();
    test_reserved_bits_and_masking();
    test_extended_lengths();
    test_random_frames();
    test_close_then_halt();

    in_valid_i <= 1'b0;

    // Let every predicted result arrive, then give the pipeline time to show anything extra.
    while (deframed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d frames, checked %0d deframed results.",
             bytes_sent, frames_sent, results_checked);
    $display("Covered empty, masked, reserved-bit and extended-length frames and the close halt.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
